### hdl/mtpu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package mtpu_pkg;
	localparam int unsigned NODES = 1024;
	localparam int unsigned NODE_W = $clog2(NODES);
	localparam int unsigned STRIDE = 8;
	localparam int unsigned ADDR_W = NODE_W + STRIDE;
	localparam int unsigned DEPTH = NODES * 256;
	localparam int unsigned CNT_W = $clog2(NODES + 1);
	localparam int unsigned HOP_W = 32;
	localparam int unsigned ENTRY_W = NODE_W + 1 + HOP_W;
	localparam logic [HOP_W-1:0] NO_HOP = '1;
	localparam logic [7:0] MAX_LEN = 8'd128;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_BAD_LEN = 2'd1,
		ST_POOL_FULL = 2'd2,
		ST_NO_PATH = 2'd3
	} status_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECIDE,
		S_READ,
		S_EXPAND,
		S_DONE,
		S_OUT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;
		logic clear_wr;
		logic read;
		logic exp_read;
		logic descend;
		logic link;
		logic mark_last;
		logic expand_wr;
		logic count_up;
		logic count_down;
		logic set_default;
		logic clr_default;
		logic set_status;
		status_t status;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic clear_last;
		logic len_bad;
		logic len_zero;
		logic is_del;
		logic full_byte;
		logic at_last_byte;
		logic child_zero;
		logic pool_full;
		logic has_rest;
		logic expand_last;
	} sts_t;
endpackage
`default_nettype wire

### hdl/multibit_trie_prefix_update.sv
`timescale 1ns / 1ps
`default_nettype none
// Each whole prefix byte takes a decide step and a read step; a partial last byte adds a
// setup read and a write per expanded entry; then a count step updates the route total.
// Throughput: one word at a time; the next word is taken the cycle after the result leaves.
// The entry memory does one read and one write per cycle; expansion overlaps them.
// Reset clears control state, then a clearing pass over all NODES*256 = 262144 entries
// zeroes the entry memory before the first word is taken.
module multibit_trie_prefix_update (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire logic mode,
	input wire logic [63:0] prefix_high,
	input wire logic [63:0] prefix_low,
	input wire logic [7:0] prefix_length,
	input wire logic [31:0] hop_value,
	output logic out_valid,
	input wire logic out_stall,
	output logic [1:0] status,
	output logic [31:0] route_total
);
	mtpu_pkg::cmd_t cmd;
	mtpu_pkg::sts_t sts;

	mtpu_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .sts(sts), .cmd(cmd)
	);

	mtpu_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .mode(mode), .prefix_high(prefix_high),
		.prefix_low(prefix_low), .prefix_length(prefix_length),
		.hop_value(hop_value), .cmd(cmd), .sts(sts), .status(status),
		.route_total(route_total)
	);
endmodule
`default_nettype wire

### hdl/mtpu_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
module mtpu_datapath (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic mode,
	input wire logic [63:0] prefix_high,
	input wire logic [63:0] prefix_low,
	input wire logic [7:0] prefix_length,
	input wire logic [31:0] hop_value,
	input wire mtpu_pkg::cmd_t cmd,
	output mtpu_pkg::sts_t sts,
	output logic [1:0] status,
	output logic [31:0] route_total
);
	logic [mtpu_pkg::ENTRY_W-1:0] mem [mtpu_pkg::DEPTH];
	logic [mtpu_pkg::ENTRY_W-1:0] rd_q;
	logic [127:0] prefix_q;
	logic [7:0] len_q;
	logic del_q;
	logic [31:0] hop_q;
	logic [7:0] depth_q;
	logic [mtpu_pkg::NODE_W-1:0] node_q;
	logic [mtpu_pkg::CNT_W-1:0] used_q;
	logic [mtpu_pkg::ADDR_W-1:0] clr_q;
	logic [7:0] exp_q;
	logic [31:0] count_q;
	logic [1:0] status_q;
	logic [31:0] dhop_q;
	logic dvalid_q;

	logic [7:0] cur_byte;
	logic [7:0] rest;
	logic [7:0] span_mask;
	logic [7:0] exp_base;
	logic [7:0] exp_rd;
	logic [mtpu_pkg::NODE_W-1:0] child;
	logic [mtpu_pkg::NODE_W-1:0] new_node;
	logic [mtpu_pkg::ADDR_W-1:0] slot;
	logic [mtpu_pkg::ADDR_W-1:0] rd_addr;
	logic [mtpu_pkg::ADDR_W-1:0] wr_addr;
	logic [mtpu_pkg::ENTRY_W-1:0] wr_data;
	logic wr_en;
	logic [mtpu_pkg::HOP_W-1:0] w_hop;

	assign cur_byte = prefix_q[8'd127 - {depth_q[6:0]} -: 8];
	assign rest = len_q - depth_q;
	assign span_mask = (8'd1 << (8'd8 - rest)) - 8'd1;
	assign exp_base = cur_byte & ~span_mask;
	assign child = rd_q[mtpu_pkg::ENTRY_W-1 -: mtpu_pkg::NODE_W];
	assign new_node = used_q[mtpu_pkg::NODE_W-1:0];
	assign slot = {node_q, cur_byte};
	assign w_hop = del_q ? mtpu_pkg::NO_HOP : hop_q;
	// during expansion the read runs one entry ahead of the write
	assign exp_rd = cmd.expand_wr ? exp_q + 8'd1 : exp_q;
	assign rd_addr = cmd.exp_read ? {node_q, exp_base | exp_rd} : slot;

	always_comb begin
		sts.clear_last = (clr_q == mtpu_pkg::ADDR_W'(mtpu_pkg::DEPTH - 1));
		sts.len_bad = len_q > mtpu_pkg::MAX_LEN;
		sts.len_zero = len_q == 8'd0;
		sts.is_del = del_q;
		sts.full_byte = (depth_q + 8'd8) <= len_q;
		sts.at_last_byte = (depth_q + 8'd8) == len_q;
		sts.child_zero = child == '0;
		sts.pool_full = used_q >= mtpu_pkg::CNT_W'(mtpu_pkg::NODES);
		sts.has_rest = depth_q < len_q;
		sts.expand_last = exp_q == span_mask;
	end

	always_comb begin
		wr_en = 1'b0;
		wr_addr = slot;
		wr_data = rd_q;
		if (cmd.clear_wr) begin
			wr_en = 1'b1;
			wr_addr = clr_q;
			wr_data = '0;
		end else if (cmd.link) begin
			wr_en = 1'b1;
			wr_data = {new_node, rd_q[mtpu_pkg::HOP_W:0]};
		end else if (cmd.mark_last) begin
			wr_en = 1'b1;
			wr_data = {child, ~del_q, w_hop};
		end else if (cmd.expand_wr) begin
			wr_en = 1'b1;
			// expanded entries keep their child pointer: read-modify-write
			wr_addr = {node_q, exp_base | exp_q};
			wr_data = {child, ~del_q, w_hop};
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) mem[wr_addr] <= wr_data;
		if (cmd.read || cmd.exp_read) rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
			used_q <= mtpu_pkg::CNT_W'(2);
			count_q <= '0;
			dhop_q <= mtpu_pkg::NO_HOP;
			dvalid_q <= 1'b0;
			status_q <= '0;
			depth_q <= '0;
			node_q <= mtpu_pkg::NODE_W'(1);
			exp_q <= '0;
		end else begin
			if (cmd.clear_wr) clr_q <= clr_q + 1'b1;
			if (cmd.load) begin
				depth_q <= '0;
				node_q <= mtpu_pkg::NODE_W'(1);
				exp_q <= '0;
			end
			if (cmd.link) begin
				used_q <= used_q + 1'b1;
				node_q <= new_node;
				depth_q <= depth_q + 8'd8;
			end else if (cmd.descend) begin
				node_q <= child;
				depth_q <= depth_q + 8'd8;
			end
			if (cmd.expand_wr) exp_q <= exp_q + 8'd1;
			if (cmd.count_up && count_q != '1) count_q <= count_q + 32'd1;
			if (cmd.count_down && count_q != '0) count_q <= count_q - 32'd1;
			if (cmd.set_default) begin
				dvalid_q <= 1'b1;
				dhop_q <= hop_q;
			end
			if (cmd.clr_default) begin
				dvalid_q <= 1'b0;
				dhop_q <= mtpu_pkg::NO_HOP;
			end
			if (cmd.set_status) status_q <= cmd.status;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prefix_q <= {prefix_high, prefix_low};
			len_q <= prefix_length;
			del_q <= mode;
			hop_q <= hop_value;
		end
	end

	assign status = status_q;
	assign route_total = count_q;

	a_used_range: assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= mtpu_pkg::CNT_W'(mtpu_pkg::NODES))
		else $error("node pool overrun");
	a_link_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.link |=> used_q == $past(used_q) + 1'b1)
		else $error("link without allocation");
	a_count_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.count_up && count_q == '1) |=> count_q == '1)
		else $error("count wrapped");
	a_default_pair: assert property (@(posedge clk) disable iff (!arst_n)
		!dvalid_q |-> dhop_q == mtpu_pkg::NO_HOP)
		else $error("default route cleared with a hop");
endmodule
`default_nettype wire

### hdl/mtpu_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module mtpu_ctrl (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input wire logic out_stall,
	input wire mtpu_pkg::sts_t sts,
	output mtpu_pkg::cmd_t cmd
);
	mtpu_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= mtpu_pkg::S_CLEAR;
		else state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.status = mtpu_pkg::ST_OK;
		in_stall = 1'b1;
		out_valid = 1'b0;
		unique case (state_q)
			mtpu_pkg::S_CLEAR: begin
				cmd.clear_wr = 1'b1;
				if (sts.clear_last) state_d = mtpu_pkg::S_IDLE;
			end
			mtpu_pkg::S_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = mtpu_pkg::S_DECIDE;
				end
			end
			mtpu_pkg::S_DECIDE: begin
				cmd.set_status = 1'b1;
				if (sts.len_bad) begin
					cmd.status = mtpu_pkg::ST_BAD_LEN;
					state_d = mtpu_pkg::S_OUT;
				end else if (sts.len_zero) begin
					cmd.set_default = !sts.is_del;
					cmd.clr_default = sts.is_del;
					cmd.count_up = !sts.is_del;
					cmd.count_down = sts.is_del;
					state_d = mtpu_pkg::S_OUT;
				end else if (sts.full_byte) begin
					cmd.read = 1'b1;
					state_d = mtpu_pkg::S_READ;
				end else if (sts.has_rest) begin
					// fetch the first entry of the expanded run
					cmd.exp_read = 1'b1;
					state_d = mtpu_pkg::S_EXPAND;
				end else begin
					state_d = mtpu_pkg::S_DONE;
				end
			end
			mtpu_pkg::S_READ: begin
				if (sts.at_last_byte) begin
					cmd.mark_last = 1'b1;
					state_d = mtpu_pkg::S_DONE;
				end else if (!sts.child_zero) begin
					cmd.descend = 1'b1;
					state_d = mtpu_pkg::S_DECIDE;
				end else if (sts.is_del) begin
					cmd.set_status = 1'b1;
					cmd.status = mtpu_pkg::ST_NO_PATH;
					state_d = mtpu_pkg::S_OUT;
				end else if (sts.pool_full) begin
					cmd.set_status = 1'b1;
					cmd.status = mtpu_pkg::ST_POOL_FULL;
					state_d = mtpu_pkg::S_OUT;
				end else begin
					cmd.link = 1'b1;
					state_d = mtpu_pkg::S_DECIDE;
				end
			end
			mtpu_pkg::S_EXPAND: begin
				// write this entry while the next one is fetched
				cmd.expand_wr = 1'b1;
				cmd.exp_read = !sts.expand_last;
				if (sts.expand_last) state_d = mtpu_pkg::S_DONE;
			end
			mtpu_pkg::S_DONE: begin
				cmd.count_up = !sts.is_del;
				cmd.count_down = sts.is_del;
				state_d = mtpu_pkg::S_OUT;
			end
			mtpu_pkg::S_OUT: begin
				out_valid = 1'b1;
				if (!out_stall) state_d = mtpu_pkg::S_IDLE;
			end
			default: state_d = mtpu_pkg::S_IDLE;
		endcase
	end
endmodule
`default_nettype wire
